[rtl/dryer_phase_sequencer_macros.svh]
// Assertion macros for the dryer phase sequencer.
`ifndef DRYER_PHASE_SEQUENCER_MACROS_SVH
`define DRYER_PHASE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define DPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dryer phase sequencer: implication check failed");
`define DPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dryer phase sequencer: next-cycle check failed");
`else
`define DPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/dps_pkg.sv]
// Types, codes and constants shared by the dryer phase sequencer files.
package dps_pkg;

  localparam int TimeBits  = 24;
  localparam int TimerBits = 16;
  localparam int RemBits   = 32;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam logic [TimeBits-1:0]  TimeMax      = '1;
  localparam logic [TimerBits-1:0] CooldownSecs = TimerBits'(120);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_RESTORE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SES_STOPPED = 2'd0,
    SES_RUNNING = 2'd1,
    SES_COOLING = 2'd2
  } session_t;

  typedef enum logic [2:0] {
    PH_STOP    = 3'd0,
    PH_CLIMATE = 3'd1,
    PH_INIT    = 3'd2,
    PH_MIXING  = 3'd3,
    PH_EXTRACT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DM_DISABLED  = 2'd0,
    DM_THRESHOLD = 2'd1,
    DM_OPEN      = 2'd2
  } damper_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CLIMATE_PROGRAM     = 3'd0,
    CFG_TARGET_HUMIDITY     = 3'd1,
    CFG_TARGET_TEMPERATURE  = 3'd2,
    CFG_INIT_SECONDS        = 3'd3,
    CFG_MIXING_SECONDS      = 3'd4,
    CFG_EXTRACTION_SECONDS  = 3'd5,
    CFG_DAMPER_OPEN_SECONDS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                  climate_program;
    logic [9:0]            target_humidity;
    logic signed [11:0]    target_temperature;
    logic [TimerBits-1:0]  init_seconds;
    logic [TimerBits-1:0]  mixing_seconds;
    logic [TimerBits-1:0]  extraction_seconds;
    logic [TimerBits-1:0]  damper_open_seconds;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic signed [11:0]   temperature;
    logic [9:0]           humidity;
    logic                 dehumidifier_fitted;
    logic [2:0]           restore_phase;
    logic [TimeBits-1:0]  restore_phase_secs;
    logic [TimeBits-1:0]  restore_total_secs;
  } item_t;

  typedef struct packed {
    session_t              session;
    phase_t                phase;
    damper_t               damper;
    logic [TimeBits-1:0]   phase_cnt;
    logic [TimeBits-1:0]   total_cnt;
    logic [TimerBits-1:0]  sub_left;
    logic                  sub_flag;
    logic [TimerBits-1:0]  cool_left;
  } state_t;

  typedef struct packed {
    session_t             session_state;
    phase_t               phase;
    damper_t              damper_mode;
    logic [1:0]           renewal_count;
    logic                 damper_timer_reset;
    logic                 control_reset;
    logic                 heaters_off;
    logic                 sub_extraction_on;
    logic [TimeBits-1:0]  phase_secs;
    logic [TimeBits-1:0]  total_secs;
  } result_t;

  localparam state_t StateReset = '{
    session:   SES_STOPPED,
    phase:     PH_STOP,
    damper:    DM_DISABLED,
    phase_cnt: '0,
    total_cnt: '0,
    sub_left:  '0,
    sub_flag:  1'b0,
    cool_left: '0
  };

endpackage

[rtl/dps_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface dps_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic signed [11:0]            temperature;
  logic [9:0]                    humidity;
  logic                          dehumidifier_fitted;
  logic [2:0]                    restore_phase;
  logic [dps_pkg::TimeBits-1:0]  restore_phase_secs;
  logic [dps_pkg::TimeBits-1:0]  restore_total_secs;

  modport source (
    output valid, op, temperature, humidity, dehumidifier_fitted,
    output restore_phase, restore_phase_secs, restore_total_secs,
    input  ready
  );
  modport sink (
    input  valid, op, temperature, humidity, dehumidifier_fitted,
    input  restore_phase, restore_phase_secs, restore_total_secs,
    output ready
  );
endinterface

interface dps_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    session_state;
  logic [2:0]                    phase;
  logic [1:0]                    damper_mode;
  logic [1:0]                    renewal_count;
  logic                          damper_timer_reset;
  logic                          control_reset;
  logic                          heaters_off;
  logic                          sub_extraction_on;
  logic [dps_pkg::TimeBits-1:0]  phase_secs;
  logic [dps_pkg::TimeBits-1:0]  total_secs;

  modport source (
    output valid, session_state, phase, damper_mode, renewal_count,
    output damper_timer_reset, control_reset, heaters_off, sub_extraction_on,
    output phase_secs, total_secs,
    input  ready
  );
  modport sink (
    input  valid, session_state, phase, damper_mode, renewal_count,
    input  damper_timer_reset, control_reset, heaters_off, sub_extraction_on,
    input  phase_secs, total_secs,
    output ready
  );
endinterface

interface dps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dps_pkg::CfgIdxBits-1:0]   index;
  logic [dps_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dps_step.sv]
// Next-state and result logic for one item of the dryer phase sequencer.
module dps_step (
  input  dps_pkg::state_t  st_i,
  input  dps_pkg::cfg_t    cfg_i,
  input  dps_pkg::item_t   item_i,
  output dps_pkg::state_t  st_o,
  output dps_pkg::result_t res_o
);

  typedef struct packed {
    dps_pkg::state_t st;
    logic [1:0]      renewals;
    logic            timer_rst;
    logic            ctrl_rst;
    logic            heat_off;
  } work_t;

  function automatic work_t set_damper(work_t w, dps_pkg::damper_t mode);
    work_t r;
    r = w;
    if (mode != r.st.damper) begin
      r.renewals = r.renewals + 2'd1;
    end
    r.st.damper = mode;
    r.timer_rst = 1'b1;
    return r;
  endfunction

  function automatic work_t enter_phase(work_t w, dps_pkg::phase_t ph, logic dehum);
    work_t r;
    r = w;
    r.st.phase     = ph;
    r.st.phase_cnt = '0;
    unique case (ph)
      dps_pkg::PH_CLIMATE: begin
        r = set_damper(r, dehum ? dps_pkg::DM_DISABLED : dps_pkg::DM_THRESHOLD);
        r.st.sub_flag = 1'b0;
        r.st.sub_left = '0;
        r.ctrl_rst    = 1'b1;
      end
      dps_pkg::PH_INIT: begin
        r = set_damper(r, dps_pkg::DM_DISABLED);
        r.st.sub_flag = 1'b0;
        r.st.sub_left = '0;
        r.ctrl_rst    = 1'b1;
      end
      dps_pkg::PH_MIXING:  r = set_damper(r, dps_pkg::DM_DISABLED);
      dps_pkg::PH_EXTRACT: r = set_damper(r, dps_pkg::DM_OPEN);
      default: ;
    endcase
    return r;
  endfunction

  work_t                            w;
  logic                             dehum;
  logic                             hum_on;
  logic                             hum_hit;
  logic                             to_extract;
  logic [dps_pkg::TimeBits-1:0]     elapsed;
  logic [dps_pkg::RemBits-1:0]      remaining;
  dps_pkg::phase_t                  rph;

  always_comb begin
    w.st       = st_i;
    w.renewals = 2'd0;
    w.timer_rst = 1'b0;
    w.ctrl_rst  = 1'b0;
    w.heat_off  = 1'b0;
    dehum      = item_i.dehumidifier_fitted;
    hum_on     = (cfg_i.target_humidity != 10'd0);
    hum_hit    = hum_on && (item_i.humidity >= cfg_i.target_humidity);
    to_extract = 1'b0;
    elapsed    = '0;
    remaining  = '0;
    rph        = dps_pkg::PH_STOP;

    unique case (item_i.op)
      dps_pkg::OP_TICK: begin
        if (w.st.session == dps_pkg::SES_RUNNING) begin
          if (w.st.phase_cnt != dps_pkg::TimeMax) begin
            w.st.phase_cnt = w.st.phase_cnt + 1'b1;
          end
          if (w.st.total_cnt != dps_pkg::TimeMax) begin
            w.st.total_cnt = w.st.total_cnt + 1'b1;
          end
          if (w.st.sub_flag && (w.st.sub_left != '0)) begin
            w.st.sub_left = w.st.sub_left - 1'b1;
          end
          elapsed = w.st.phase_cnt;
          case (w.st.phase)
            dps_pkg::PH_INIT: begin
              if (hum_on && !dehum) begin
                if (w.st.sub_flag) begin
                  if (w.st.sub_left == '0) begin
                    w.st.sub_flag = 1'b0;
                    w = set_damper(w, dps_pkg::DM_DISABLED);
                  end
                end else if (hum_hit) begin
                  remaining = dps_pkg::RemBits'(cfg_i.init_seconds)
                            - dps_pkg::RemBits'(elapsed);
                  if (remaining > dps_pkg::RemBits'(cfg_i.damper_open_seconds)) begin
                    w.st.sub_flag = 1'b1;
                    w.st.sub_left = cfg_i.damper_open_seconds;
                    w = set_damper(w, dps_pkg::DM_OPEN);
                  end else begin
                    w = enter_phase(w, dps_pkg::PH_EXTRACT, dehum);
                    to_extract = 1'b1;
                  end
                end
              end
              if (!to_extract && ((item_i.temperature >= cfg_i.target_temperature) ||
                  (elapsed >= dps_pkg::TimeBits'(cfg_i.init_seconds)))) begin
                w = enter_phase(w, dps_pkg::PH_MIXING, dehum);
              end
            end
            dps_pkg::PH_MIXING: begin
              if (!dehum && (hum_hit ||
                  (elapsed >= dps_pkg::TimeBits'(cfg_i.mixing_seconds)))) begin
                w = enter_phase(w, dps_pkg::PH_EXTRACT, dehum);
              end
            end
            dps_pkg::PH_EXTRACT: begin
              if (dehum || (elapsed >= dps_pkg::TimeBits'(cfg_i.extraction_seconds))) begin
                w = enter_phase(w, dps_pkg::PH_MIXING, dehum);
              end
            end
            default: ;
          endcase
        end else if (w.st.session == dps_pkg::SES_COOLING) begin
          if (w.st.cool_left != '0) begin
            w.st.cool_left = w.st.cool_left - 1'b1;
          end
          if (w.st.cool_left == '0) begin
            w.st.session = dps_pkg::SES_STOPPED;
          end
        end
      end
      dps_pkg::OP_START: begin
        w.st.session   = dps_pkg::SES_RUNNING;
        w.st.total_cnt = '0;
        w = enter_phase(w, cfg_i.climate_program ? dps_pkg::PH_CLIMATE : dps_pkg::PH_INIT,
                        dehum);
      end
      dps_pkg::OP_STOP: begin
        w.st.session   = dps_pkg::SES_COOLING;
        w.st.phase     = dps_pkg::PH_STOP;
        w.st.cool_left = dps_pkg::CooldownSecs;
        w.st.damper    = dps_pkg::DM_DISABLED;
        w.heat_off     = 1'b1;
        w.timer_rst    = 1'b1;
      end
      dps_pkg::OP_RESTORE: begin
        if (item_i.restore_phase > 3'(dps_pkg::PH_EXTRACT)) begin
          rph = dps_pkg::PH_STOP;
        end else begin
          rph = dps_pkg::phase_t'(item_i.restore_phase);
        end
        w.st.session   = dps_pkg::SES_RUNNING;
        w.st.total_cnt = item_i.restore_total_secs;
        w = enter_phase(w, rph, dehum);
        w.st.phase_cnt = item_i.restore_phase_secs;
      end
      default: ;
    endcase
  end

  assign st_o = w.st;

  always_comb begin
    res_o.session_state      = w.st.session;
    res_o.phase              = w.st.phase;
    res_o.damper_mode        = w.st.damper;
    res_o.renewal_count      = w.renewals;
    res_o.damper_timer_reset = w.timer_rst;
    res_o.control_reset      = w.ctrl_rst;
    res_o.heaters_off        = w.heat_off;
    res_o.sub_extraction_on  = w.st.sub_flag;
    res_o.phase_secs         = w.st.phase_cnt;
    res_o.total_secs         = w.st.total_cnt;
  end

endmodule

[rtl/dryer_phase_sequencer.sv]
// Top level of the dryer phase sequencer: channel registers, state and configuration.
//
// One item (tick, start, stop or restore) is taken every clock cycle unless the input
// stalls. The input beat loads the input register, the whole session update is computed
// in the single stage behind it, and the result is loaded into the result register and
// offered from there. The input side keeps accepting while a result waits, and stalls
// only when both registers are full and the waiting result is not taken in that cycle.
// Configuration writes are taken in any cycle (cfg ready is tied high) and take effect
// on the next item processed; write them only while no item is in flight. Indexes beyond
// the last register are ignored.
`include "dryer_phase_sequencer_macros.svh"

module dryer_phase_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  dps_in_if.sink            in_if,
  dps_out_if.source         out_if,
  dps_cfg_if.sink           cfg_if
);

  dps_pkg::cfg_t     cfg_r;
  dps_pkg::state_t   st_r;
  dps_pkg::state_t   st_nxt;
  dps_pkg::item_t    in_r;
  dps_pkg::result_t  out_r;
  dps_pkg::result_t  res_nxt;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              load_out;

  assign load_out     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || load_out;
  assign cfg_if.ready = 1'b1;

  dps_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg_r),
    .item_i (in_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= dps_pkg::StateReset;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_r.op                  <= dps_pkg::op_t'(in_if.op);
      in_r.temperature         <= in_if.temperature;
      in_r.humidity            <= in_if.humidity;
      in_r.dehumidifier_fitted <= in_if.dehumidifier_fitted;
      in_r.restore_phase       <= in_if.restore_phase;
      in_r.restore_phase_secs  <= in_if.restore_phase_secs;
      in_r.restore_total_secs  <= in_if.restore_total_secs;
    end
    if (load_out) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (dps_pkg::cfg_idx_t'(cfg_if.index))
        dps_pkg::CFG_CLIMATE_PROGRAM:     cfg_r.climate_program     <= cfg_if.data[0];
        dps_pkg::CFG_TARGET_HUMIDITY:     cfg_r.target_humidity     <= cfg_if.data[9:0];
        dps_pkg::CFG_TARGET_TEMPERATURE:  cfg_r.target_temperature  <= $signed(cfg_if.data[11:0]);
        dps_pkg::CFG_INIT_SECONDS:        cfg_r.init_seconds        <= cfg_if.data;
        dps_pkg::CFG_MIXING_SECONDS:      cfg_r.mixing_seconds      <= cfg_if.data;
        dps_pkg::CFG_EXTRACTION_SECONDS:  cfg_r.extraction_seconds  <= cfg_if.data;
        dps_pkg::CFG_DAMPER_OPEN_SECONDS: cfg_r.damper_open_seconds <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.session_state      = out_r.session_state;
  assign out_if.phase              = out_r.phase;
  assign out_if.damper_mode        = out_r.damper_mode;
  assign out_if.renewal_count      = out_r.renewal_count;
  assign out_if.damper_timer_reset = out_r.damper_timer_reset;
  assign out_if.control_reset      = out_r.control_reset;
  assign out_if.heaters_off        = out_r.heaters_off;
  assign out_if.sub_extraction_on  = out_r.sub_extraction_on;
  assign out_if.phase_secs         = out_r.phase_secs;
  assign out_if.total_secs         = out_r.total_secs;

  `DPS_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_r && !load_out, in_valid_r)
  `DPS_ASSERT_IMP(a_idle_stop_phase, clk, rst_n,
                  st_r.session != dps_pkg::SES_RUNNING, st_r.phase == dps_pkg::PH_STOP)
  `DPS_ASSERT_IMP(a_renewal_max, clk, rst_n, out_valid_r, out_r.renewal_count != 2'd3)
  `DPS_ASSERT_IMP(a_heat_off_cooling, clk, rst_n, out_valid_r && out_r.heaters_off,
                  (out_r.session_state == dps_pkg::SES_COOLING) &&
                  (out_r.phase == dps_pkg::PH_STOP))
  `DPS_ASSERT_IMP(a_ctrl_rst_phase, clk, rst_n, out_valid_r && out_r.control_reset,
                  (out_r.phase == dps_pkg::PH_CLIMATE) || (out_r.phase == dps_pkg::PH_INIT))

endmodule

[sim/dps_session_checker.sv]
// Checker for the dryer phase sequencer: watches all channels, predicts each result, compares.
`timescale 1ns / 100ps

module dps_session_checker
  import dps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dps_in_if    in_ch,
  dps_out_if   out_ch,
  dps_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  logic               climate_sel;
  logic [9:0]         hum_target;
  logic signed [11:0] temp_target;
  logic [15:0]        init_limit, mix_limit, ext_limit, open_limit;

  session_t      ses;
  phase_t        ph;
  damper_t       dmp;
  logic [23:0]   ph_secs, tot_secs;
  logic [15:0]   sub_left, cool_left;
  logic          sub_on;
  logic [1:0]    renew;
  logic          timer_rst, ctrl_rst, heat_cut;

  result_t expected_reports[$];

  function automatic void command_damper(damper_t mode);
    if (mode != dmp) renew = renew + 2'd1;
    dmp = mode;
    timer_rst = 1'b1;
  endfunction

  function automatic void switch_phase(phase_t p, logic dehum);
    ph = p;
    ph_secs = '0;
    case (p)
      PH_CLIMATE: begin
        command_damper(dehum ? DM_DISABLED : DM_THRESHOLD);
        sub_on = 1'b0;
        sub_left = '0;
        ctrl_rst = 1'b1;
      end
      PH_INIT: begin
        command_damper(DM_DISABLED);
        sub_on = 1'b0;
        sub_left = '0;
        ctrl_rst = 1'b1;
      end
      PH_MIXING:  command_damper(DM_DISABLED);
      PH_EXTRACT: command_damper(DM_OPEN);
      default: ;
    endcase
  endfunction

  function automatic result_t predict_report(item_t it);
    result_t            r;
    logic signed [11:0] temp;
    logic               dehum, hum_on, hum_hit, to_extract;
    logic [31:0]        remaining;
    phase_t             rp;
    temp = it.temperature;
    dehum = it.dehumidifier_fitted;
    renew = '0;
    timer_rst = 1'b0;
    ctrl_rst = 1'b0;
    heat_cut = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (ses == SES_RUNNING) begin
          if (ph_secs != TimeMax) ph_secs = ph_secs + 24'd1;
          if (tot_secs != TimeMax) tot_secs = tot_secs + 24'd1;
          if (sub_on && sub_left != '0) sub_left = sub_left - 16'd1;
          hum_on = hum_target != '0;
          hum_hit = hum_on && (it.humidity >= hum_target);
          case (ph)
            PH_INIT: begin
              to_extract = 1'b0;
              if (hum_on && !dehum) begin
                if (sub_on) begin
                  if (sub_left == '0) begin
                    sub_on = 1'b0;
                    command_damper(DM_DISABLED);
                  end
                end else if (hum_hit) begin
                  remaining = 32'(init_limit) - 32'(ph_secs);
                  if (remaining > 32'(open_limit)) begin
                    sub_on = 1'b1;
                    sub_left = open_limit;
                    command_damper(DM_OPEN);
                  end else begin
                    switch_phase(PH_EXTRACT, dehum);
                    to_extract = 1'b1;
                  end
                end
              end
              if (!to_extract && (temp >= temp_target || ph_secs >= 24'(init_limit)))
                switch_phase(PH_MIXING, dehum);
            end
            PH_MIXING: begin
              if (!dehum && (hum_hit || ph_secs >= 24'(mix_limit)))
                switch_phase(PH_EXTRACT, dehum);
            end
            PH_EXTRACT: begin
              if (dehum || ph_secs >= 24'(ext_limit))
                switch_phase(PH_MIXING, dehum);
            end
            default: ;
          endcase
        end else if (ses == SES_COOLING) begin
          if (cool_left != '0) cool_left = cool_left - 16'd1;
          if (cool_left == '0) ses = SES_STOPPED;
        end
      end
      OP_START: begin
        ses = SES_RUNNING;
        tot_secs = '0;
        switch_phase(climate_sel ? PH_CLIMATE : PH_INIT, dehum);
      end
      OP_STOP: begin
        ses = SES_COOLING;
        ph = PH_STOP;
        cool_left = CooldownSecs;
        heat_cut = 1'b1;
        dmp = DM_DISABLED;
        timer_rst = 1'b1;
      end
      default: begin
        rp = (it.restore_phase > PH_EXTRACT) ? PH_STOP : phase_t'(it.restore_phase);
        ses = SES_RUNNING;
        tot_secs = it.restore_total_secs;
        switch_phase(rp, dehum);
        ph_secs = it.restore_phase_secs;
      end
    endcase
    r.session_state      = ses;
    r.phase              = ph;
    r.damper_mode        = dmp;
    r.renewal_count      = renew;
    r.damper_timer_reset = timer_rst;
    r.control_reset      = ctrl_rst;
    r.heaters_off        = heat_cut;
    r.sub_extraction_on  = sub_on;
    r.phase_secs         = ph_secs;
    r.total_secs         = tot_secs;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("ses=%0d ph=%0d dmp=%0d ren=%0d trst=%0b crst=%0b hoff=%0b sub=%0b %s",
                     r.session_state, r.phase, r.damper_mode, r.renewal_count,
                     r.damper_timer_reset, r.control_reset, r.heaters_off,
                     r.sub_extraction_on,
                     $sformatf("psec=%0d tsec=%0d", r.phase_secs, r.total_secs));
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t got, want;
    if (!rst_n) begin
      climate_sel = 1'b0;
      hum_target = '0;
      temp_target = '0;
      init_limit = '0;
      mix_limit = '0;
      ext_limit = '0;
      open_limit = '0;
      ses = SES_STOPPED;
      ph = PH_STOP;
      dmp = DM_DISABLED;
      ph_secs = '0;
      tot_secs = '0;
      sub_left = '0;
      cool_left = '0;
      sub_on = 1'b0;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.session_state      = session_t'(out_ch.session_state);
        got.phase              = phase_t'(out_ch.phase);
        got.damper_mode        = damper_t'(out_ch.damper_mode);
        got.renewal_count      = out_ch.renewal_count;
        got.damper_timer_reset = out_ch.damper_timer_reset;
        got.control_reset      = out_ch.control_reset;
        got.heaters_off        = out_ch.heaters_off;
        got.sub_extraction_on  = out_ch.sub_extraction_on;
        got.phase_secs         = out_ch.phase_secs;
        got.total_secs         = out_ch.total_secs;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t: expected %s", $realtime, show(want));
              $display("                 actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_CLIMATE_PROGRAM:     climate_sel = cfg_ch.data[0];
          CFG_TARGET_HUMIDITY:     hum_target = cfg_ch.data[9:0];
          CFG_TARGET_TEMPERATURE:  temp_target = cfg_ch.data[11:0];
          CFG_INIT_SECONDS:        init_limit = cfg_ch.data;
          CFG_MIXING_SECONDS:      mix_limit = cfg_ch.data;
          CFG_EXTRACTION_SECONDS:  ext_limit = cfg_ch.data;
          CFG_DAMPER_OPEN_SECONDS: open_limit = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        it.op                  = op_t'(in_ch.op);
        it.temperature         = in_ch.temperature;
        it.humidity            = in_ch.humidity;
        it.dehumidifier_fitted = in_ch.dehumidifier_fitted;
        it.restore_phase       = in_ch.restore_phase;
        it.restore_phase_secs  = in_ch.restore_phase_secs;
        it.restore_total_secs  = in_ch.restore_total_secs;
        expected_reports.push_back(predict_report(it));
      end
    end
    pending = expected_reports.size();
  end

endmodule

[sim/dryer_phase_sequencer_tb.sv]
// Testbench top for the dryer phase sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dryer_phase_sequencer_tb;
  import dps_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 235;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic       clk;
  logic       rst_n;
  int         fail_count, pending;
  int         cycles = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  logic [9:0] hum_target = '0;

  dps_in_if  in_ch ();
  dps_out_if out_ch ();
  dps_cfg_if cfg_ch ();

  dryer_phase_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  dps_session_checker report_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rx_mode_t mode;
    int       span;
    out_ch.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= ($urandom_range(0, 1) == 0);
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  function automatic item_t make_item(op_t op, int temp, int hum, logic dehum,
                                      logic [2:0] rp, logic [23:0] ps, logic [23:0] ts);
    item_t it;
    it.op                  = op;
    it.temperature         = 12'(temp);
    it.humidity            = 10'(hum);
    it.dehumidifier_fitted = dehum;
    it.restore_phase       = rp;
    it.restore_phase_secs  = ps;
    it.restore_total_secs  = ts;
    return it;
  endfunction

  function automatic int rand_temp();
    return int'($urandom_range(0, 1650)) - 400;
  endfunction

  function automatic logic [23:0] rand_secs();
    case ($urandom_range(0, 5))
      0:       return 24'hFFFFFF - 24'($urandom_range(0, 3));
      1:       return 24'($urandom());
      default: return 24'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic put_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid               <= 1'b1;
    in_ch.op                  <= it.op;
    in_ch.temperature         <= it.temperature;
    in_ch.humidity            <= it.humidity;
    in_ch.dehumidifier_fitted <= it.dehumidifier_fitted;
    in_ch.restore_phase       <= it.restore_phase;
    in_ch.restore_phase_secs  <= it.restore_phase_secs;
    in_ch.restore_total_secs  <= it.restore_total_secs;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic tick(int temp, int hum, logic dehum);
    put_item(make_item(OP_TICK, temp, hum, dehum, PH_STOP, '0, '0));
  endtask

  task automatic restore(logic [2:0] rp, logic [23:0] ps, logic [23:0] ts, logic dehum);
    put_item(make_item(OP_RESTORE, 0, 0, dehum, rp, ps, ts));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic clim, int hum, int temp, int init_s, int mix_s,
                               int ext_s, int open_s);
    write_reg(CFG_CLIMATE_PROGRAM, 16'(clim));
    write_reg(CFG_TARGET_HUMIDITY, 16'(hum));
    write_reg(CFG_TARGET_TEMPERATURE, {4'b0, 12'(temp)});
    write_reg(CFG_INIT_SECONDS, 16'(init_s));
    write_reg(CFG_MIXING_SECONDS, 16'(mix_s));
    write_reg(CFG_EXTRACTION_SECONDS, 16'(ext_s));
    write_reg(CFG_DAMPER_OPEN_SECONDS, 16'(open_s));
    hum_target = 10'(hum);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_session();
    int   n, m, temp, hum;
    logic dehum;
    dehum = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 4) == 0)
      put_item(make_item(OP_RESTORE, rand_temp(), $urandom_range(0, 1000), dehum,
                         3'($urandom_range(0, 7)), rand_secs(), rand_secs()));
    else
      put_item(make_item(OP_START, rand_temp(), $urandom_range(0, 1000), dehum,
                         3'($urandom_range(0, 7)), 24'($urandom()), 24'($urandom())));
    temp = -400 + int'($urandom_range(0, 800));
    n = $urandom_range(4, 60);
    repeat (n) begin
      temp += $urandom_range(0, 40);
      if (temp > 1250) temp = 1250;
      if ($urandom_range(0, 3) == 0) hum = $urandom_range(int'(hum_target), 1000);
      else hum = $urandom_range(0, 1000);
      if ($urandom_range(0, 39) == 0) dehum = ~dehum;
      put_item(make_item(OP_TICK, temp, hum, dehum, 3'($urandom_range(0, 7)),
                         24'($urandom()), 24'($urandom())));
    end
    if ($urandom_range(0, 9) < 4) begin
      put_item(make_item(OP_STOP, rand_temp(), $urandom_range(0, 1000), dehum,
                         3'($urandom_range(0, 7)), 24'($urandom()), 24'($urandom())));
      m = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(110, 130);
      repeat (m)
        put_item(make_item(OP_TICK, rand_temp(), $urandom_range(0, 1000),
                           1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                           24'($urandom()), 24'($urandom())));
    end
  endtask

  initial begin
    int phase_end;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.temperature = '0;
    in_ch.humidity = '0;
    in_ch.dehumidifier_fitted = 1'b0;
    in_ch.restore_phase = '0;
    in_ch.restore_phase_secs = '0;
    in_ch.restore_total_secs = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_setting(1'b0, 500, 600, 10, 3, 2, 2);
    tick(-400, 0, 1'b0);
    put_item(make_item(OP_START, 0, 0, 1'b0, PH_STOP, '0, '0));
    tick(100, 1000, 1'b0);
    tick(100, 0, 1'b0);
    tick(100, 0, 1'b0);
    tick(1250, 0, 1'b0);
    tick(0, 1000, 1'b0);
    tick(0, 0, 1'b0);
    tick(0, 0, 1'b0);
    tick(0, 1000, 1'b1);
    tick(0, 0, 1'b0);
    tick(0, 0, 1'b0);
    tick(0, 0, 1'b1);
    put_item(make_item(OP_STOP, 0, 0, 1'b0, PH_STOP, '0, '0));
    tick(0, 0, 1'b0);
    restore(3'd7, 24'd5, 24'd9, 1'b0);
    tick(0, 0, 1'b0);
    restore(PH_EXTRACT, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    tick(0, 0, 1'b0);
    restore(PH_INIT, 24'd20, 24'd0, 1'b0);
    tick(-400, 1000, 1'b0);
    restore(PH_INIT, 24'd8, 24'd0, 1'b0);
    tick(-400, 1000, 1'b0);
    restore(PH_CLIMATE, 24'd0, 24'd0, 1'b1);
    restore(PH_CLIMATE, 24'd0, 24'd0, 1'b0);
    restore(PH_MIXING, 24'd1, 24'd1, 1'b0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: apply_setting(1'b0, 0, -400, 0, 0, 0, 0);
        1: apply_setting(1'b1, 1000, 1250, 65535, 65535, 65535, 65535);
        default:
          apply_setting(1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(200, 1000),
                        rand_temp(), $urandom_range(0, 40), $urandom_range(0, 20),
                        $urandom_range(0, 12),
                        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 3) != 0)
          run_session();
        else
          repeat ($urandom_range(1, 4))
            put_item(make_item(op_t'($urandom_range(0, 3)), rand_temp(),
                               $urandom_range(0, 1000), 1'($urandom_range(0, 1)),
                               3'($urandom_range(0, 7)), 24'($urandom()),
                               24'($urandom())));
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/dps_pkg.sv
rtl/dps_if.sv
rtl/dps_step.sv
rtl/dryer_phase_sequencer.sv
sim/dps_session_checker.sv
sim/dryer_phase_sequencer_tb.sv
